// ===== hdl/uli_pkg.sv =====
// uli_pkg: shared types and constants for the UTF-8 line indexer.
// No dependencies; imported by every module of the block.
package uli_pkg;

   localparam int unsigned OUT_W  = 32;
   localparam int unsigned QDEPTH = 2;
   localparam logic [7:0]  NL_BYTE = 8'h0A;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef enum logic [1:0] {
      KIND_CONT    = 2'd0,
      KIND_CHAR    = 2'd1,
      KIND_NEWLINE = 2'd2,
      KIND_END     = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type kind;
   } beat_type;

endpackage

// ===== hdl/uli_front.sv =====
// uli_front: accepts request beats, tracks continuation bytes, classifies each beat.
// Depends on uli_pkg.
module uli_front import uli_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_operation,
   input  logic [7:0] req_text_byte,
   output logic       push,
   output beat_type   push_beat,
   input  logic       q_full
);

   logic [1:0] skip_ff, skip_in;
   logic [1:0] lead_skip;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      priority if (req_text_byte[7] == 1'b0) begin
         lead_skip = 2'd0;
      end else if (req_text_byte[7:5] == 3'b110) begin
         lead_skip = 2'd1;
      end else if (req_text_byte[7:4] == 4'b1110) begin
         lead_skip = 2'd2;
      end else if (req_text_byte[7:3] == 5'b11110) begin
         lead_skip = 2'd3;
      end else begin
         lead_skip = 2'd0;
      end
   end

   always_comb begin
      skip_in = skip_ff;
      push_beat.kind = KIND_END;
      if (req_operation == OP_END) begin
         skip_in = 2'd0;
         push_beat.kind = KIND_END;
      end else if (skip_ff != 2'd0) begin
         skip_in = skip_ff - 2'd1;
         push_beat.kind = KIND_CONT;
      end else begin
         skip_in = lead_skip;
         push_beat.kind = (req_text_byte == NL_BYTE) ? KIND_NEWLINE : KIND_CHAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 2'd0;
      end else if (push) begin
         skip_ff <= skip_in;
      end
   end

endmodule

// ===== hdl/uli_queue.sv =====
// uli_queue: short FIFO of classified beats between front and back.
// Depends on uli_pkg.
module uli_queue import uli_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  beat_type push_beat,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output beat_type head_beat
);

   localparam int unsigned PTR_W = $clog2(QDEPTH);
   localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

   beat_type             mem_ff [QDEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;

   assign full      = (count_ff == CNT_W'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign head_beat = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/uli_back.sv =====
// uli_back: line counters and the registered response beat.
// Depends on uli_pkg; fed by uli_queue.
module uli_back import uli_pkg::*; #(
   parameter int unsigned OFFSET_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             not_empty,
   input  beat_type         head_beat,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [OUT_W-1:0] rsp_line_offset,
   output logic [OUT_W-1:0] rsp_line_bytes,
   output logic [OUT_W-1:0] rsp_line_chars,
   output logic             rsp_newline_bytes,
   output logic             rsp_final_line
);

   localparam int unsigned CNT_W = (OFFSET_BITS < OUT_W) ? OFFSET_BITS : OUT_W;

   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] start_ff, start_in;
   logic [CNT_W-1:0] bytes_ff, bytes_in;
   logic [CNT_W-1:0] chars_ff, chars_in;
   logic [CNT_W-1:0] pos_sat, bytes_sat, chars_sat;
   logic             valid_ff;
   logic [OUT_W-1:0] offset_ff, lbytes_ff, lchars_ff;
   logic             nl_ff, fin_ff;
   logic             produces, out_free;

   assign pos_sat   = (pos_ff   == '1) ? pos_ff   : pos_ff   + 1'b1;
   assign bytes_sat = (bytes_ff == '1) ? bytes_ff : bytes_ff + 1'b1;
   assign chars_sat = (chars_ff == '1) ? chars_ff : chars_ff + 1'b1;

   assign produces = (head_beat.kind == KIND_END) || (head_beat.kind == KIND_NEWLINE);
   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = not_empty && (!produces || out_free);

   always_comb begin
      pos_in   = pos_sat;
      start_in = start_ff;
      bytes_in = bytes_sat;
      chars_in = chars_ff;
      unique case (head_beat.kind)
         KIND_END: begin
            pos_in   = '0;
            start_in = '0;
            bytes_in = '0;
            chars_in = '0;
         end
         KIND_NEWLINE: begin
            start_in = pos_sat;
            bytes_in = '0;
            chars_in = '0;
         end
         KIND_CHAR: begin
            chars_in = chars_sat;
         end
         KIND_CONT: begin
            chars_in = chars_ff;
         end
         default: begin
            chars_in = chars_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         start_ff <= '0;
         bytes_ff <= '0;
         chars_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            pos_ff   <= pos_in;
            start_ff <= start_in;
            bytes_ff <= bytes_in;
            chars_ff <= chars_in;
         end
         if (pop && produces) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && produces) begin
         offset_ff <= OUT_W'(start_ff);
         lchars_ff <= OUT_W'(chars_ff);
         if (head_beat.kind == KIND_END) begin
            lbytes_ff <= OUT_W'(bytes_ff);
            nl_ff     <= 1'b0;
            fin_ff    <= 1'b1;
         end else begin
            lbytes_ff <= OUT_W'(bytes_sat);
            nl_ff     <= 1'b1;
            fin_ff    <= 1'b0;
         end
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_line_offset   = offset_ff;
   assign rsp_line_bytes    = lbytes_ff;
   assign rsp_line_chars    = lchars_ff;
   assign rsp_newline_bytes = nl_ff;
   assign rsp_final_line    = fin_ff;

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      pop && produces |-> out_free)
      else $error("response beat overwritten");

   a_nl_clear: assert property (@(posedge clock) disable iff (reset)
      pop && head_beat.kind == KIND_NEWLINE |=> bytes_ff == '0 && chars_ff == '0)
      else $error("line counters not cleared after newline");

   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      pop && head_beat.kind == KIND_END |=> pos_ff == '0 && start_ff == '0)
      else $error("position not cleared after end of text");

   a_chars_le_bytes: assert property (@(posedge clock) disable iff (reset)
      chars_ff <= bytes_ff)
      else $error("character count exceeds byte count");

endmodule

// ===== hdl/utf8_line_indexer.sv =====
// utf8_line_indexer: top level of the UTF-8 line index builder.
// Depends on uli_pkg, uli_front, uli_queue, uli_back.
//
// Request channel: one beat per text byte (req_operation = 0) or an
// end-of-text beat (req_operation = 1). Response channel: one record per
// line, emitted when a newline lead byte arrives and on end of text
// (rsp_final_line = 1, also for an empty text or one ending in newline).
// Throughput: one request beat per cycle while the queue has room; req_stall
// holds the request while it is full. The beat closing a line enters the
// 2-entry queue at the edge that accepts it, and the back registers the
// record once it pops that beat and the response register is free.
// The front tracks continuation bytes; the back holds the offset and
// line counters, which saturate at 2^min(OFFSET_BITS,32)-1.
// Reset: all counters return to zero, queue empties, rsp_valid drops.
// End of text also returns the counters to zero for the next text.
// Receiver stall: the response beat holds; the back keeps consuming
// beats that make no record, and req_stall rises once the queue fills.
module utf8_line_indexer import uli_pkg::*; #(
   parameter int unsigned OFFSET_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_operation,
   input  logic [7:0]       req_text_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [OUT_W-1:0] rsp_line_offset,
   output logic [OUT_W-1:0] rsp_line_bytes,
   output logic [OUT_W-1:0] rsp_line_chars,
   output logic             rsp_newline_bytes,
   output logic             rsp_final_line
);

   logic     push, pop, q_full, q_not_empty;
   beat_type push_beat, head_beat;

   uli_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_text_byte (req_text_byte),
      .push          (push),
      .push_beat     (push_beat),
      .q_full        (q_full)
   );

   uli_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_beat (head_beat)
   );

   uli_back #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .not_empty         (q_not_empty),
      .head_beat         (head_beat),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_line_offset   (rsp_line_offset),
      .rsp_line_bytes    (rsp_line_bytes),
      .rsp_line_chars    (rsp_line_chars),
      .rsp_newline_bytes (rsp_newline_bytes),
      .rsp_final_line    (rsp_final_line)
   );

endmodule

// ===== verif/tb_utf8_line_indexer.sv =====
`timescale 1ns / 1ps
// tb_utf8_line_indexer: self-checking testbench for the UTF-8 line indexer.
// Depends on uli_pkg and utf8_line_indexer; a scoreboard class predicts the
// line records and checks each response beat field by field.
module tb_utf8_line_indexer;
   import uli_pkg::*;

   localparam int unsigned OFFSET_BITS = 32;
   localparam longint unsigned COUNT_MAX = (OFFSET_BITS < 32) ?
      ((64'd1 << OFFSET_BITS) - 1) : 64'hFFFF_FFFF;
   localparam int unsigned RANDOM_BEATS = 400;
   localparam int unsigned LONG_HOLD_CYCLES = 80;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam longint unsigned TIMEOUT_NS = 2_000_000;

   typedef struct {
      logic [OUT_W-1:0] offset;
      logic [OUT_W-1:0] bytes;
      logic [OUT_W-1:0] chars;
      logic             nl;
      logic             fin;
   } line_rec_type;

   class line_index_board_type;
      longint unsigned byte_pos;
      longint unsigned line_start;
      longint unsigned line_len;
      longint unsigned line_char_cnt;
      int unsigned     cont_left;
      line_rec_type    pending_lines[$];
      int unsigned     n_beats;
      int unsigned     n_lines;
      int unsigned     n_texts;
      int unsigned     n_errors;

      function void clear_text();
         byte_pos = 0;
         line_start = 0;
         line_len = 0;
         line_char_cnt = 0;
         cont_left = 0;
      endfunction

      function longint unsigned bump(longint unsigned v);
         return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
      endfunction

      function int unsigned char_span(logic [7:0] b);
         casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 1;
         endcase
      endfunction

      function void push_line(logic nl, logic fin);
         line_rec_type r;
         r.offset = line_start[OUT_W-1:0];
         r.bytes  = line_len[OUT_W-1:0];
         r.chars  = line_char_cnt[OUT_W-1:0];
         r.nl     = nl;
         r.fin    = fin;
         pending_lines.push_back(r);
      endfunction

      function void note_beat(logic op, logic [7:0] b);
         n_beats++;
         if (op == OP_END) begin
            push_line(1'b0, 1'b1);
            n_texts++;
            clear_text();
            return;
         end
         line_len = bump(line_len);
         if (cont_left != 0) begin
            cont_left--;
         end else begin
            cont_left = char_span(b) - 1;
            // a newline taken as a continuation byte never gets here
            if (b == NL_BYTE) begin
               push_line(1'b1, 1'b0);
               line_start = bump(byte_pos);
               line_len = 0;
               line_char_cnt = 0;
            end else begin
               line_char_cnt = bump(line_char_cnt);
            end
         end
         byte_pos = bump(byte_pos);
      endfunction

      function void compare_field(string name, logic [OUT_W-1:0] want,
                                  logic [OUT_W-1:0] got);
         if (want !== got) begin
            n_errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         end
      endfunction

      function void check_line(logic [OUT_W-1:0] offset, logic [OUT_W-1:0] bytes,
                               logic [OUT_W-1:0] chars, logic nl, logic fin);
         line_rec_type e;
         if (pending_lines.size() == 0) begin
            n_errors++;
            $display("%0t: record expected none got off=%0d bytes=%0d chars=%0d nl=%0b fin=%0b",
                     $time, offset, bytes, chars, nl, fin);
            return;
         end
         e = pending_lines.pop_front();
         n_lines++;
         compare_field("line_offset", e.offset, offset);
         compare_field("line_bytes", e.bytes, bytes);
         compare_field("line_chars", e.chars, chars);
         compare_field("newline_bytes", OUT_W'(e.nl), OUT_W'(nl));
         compare_field("final_line", OUT_W'(e.fin), OUT_W'(fin));
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic             req_operation;
   logic [7:0]       req_text_byte;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [OUT_W-1:0] rsp_line_offset;
   logic [OUT_W-1:0] rsp_line_bytes;
   logic [OUT_W-1:0] rsp_line_chars;
   logic             rsp_newline_bytes;
   logic             rsp_final_line;

   bit long_hold = 1'b0;
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   int unsigned long_holds = 0;

   line_index_board_type board = new();

   utf8_line_indexer #(.OFFSET_BITS(OFFSET_BITS)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_text_byte     (req_text_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_line_offset   (rsp_line_offset),
      .rsp_line_bytes    (rsp_line_bytes),
      .rsp_line_chars    (rsp_line_chars),
      .rsp_newline_bytes (rsp_newline_bytes),
      .rsp_final_line    (rsp_final_line)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned r;
      int unsigned n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall = 1'b1;
            long_holds++;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
            long_hold = 1'b0;
         end else begin
            r = $urandom_range(99);
            if (rsp_steady || r < 70) n = 0;
            else if (r < 95) n = $urandom_range(1, 3);
            else n = $urandom_range(10, 30);
            if (n == 0) begin
               rsp_stall = 1'b0;
            end else begin
               rsp_stall = 1'b1;
               repeat (n) @(negedge clock);
               rsp_stall = 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_line(rsp_line_offset, rsp_line_bytes, rsp_line_chars,
                          rsp_newline_bytes, rsp_final_line);
   end

   task automatic send_beat(input logic op, input logic [7:0] b);
      int unsigned gap;
      gap = req_steady ? 0 : pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_operation = 1'($urandom);
         req_text_byte = 8'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_operation = op;
      req_text_byte = b;
      do @(posedge clock); while (req_stall);
      board.note_beat(op, b);
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending_lines.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed characters and line ends, some noise, cut-off chars and ends of text
   task automatic send_char();
      int unsigned r;
      int unsigned span;
      int unsigned keep;
      logic [7:0]  lead;
      r = $urandom_range(99);
      if (r < 40) begin
         send_beat(OP_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
      end else if (r < 55) begin
         send_beat(OP_BYTE, NL_BYTE);
      end else if (r < 85) begin
         span = $urandom_range(2, 4);
         case (span)
            2:       lead = {3'b110, 5'($urandom)};
            3:       lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
         endcase
         keep = span;
         if ($urandom_range(9) == 0) keep = $urandom_range(1, span - 1);
         send_beat(OP_BYTE, lead);
         for (int i = 1; i < keep; i++) send_beat(OP_BYTE, {2'b10, 6'($urandom)});
      end else if (r < 95) begin
         send_beat(OP_BYTE, 8'($urandom));
      end else begin
         send_beat(OP_END, 8'($urandom));
      end
   endtask

   initial begin
      logic [8:0] opening [26] = '{
         {OP_END, 8'h00},
         {OP_BYTE, 8'h41}, {OP_BYTE, NL_BYTE}, {OP_END, 8'hFF},
         {OP_BYTE, 8'h00}, {OP_BYTE, 8'h7F}, {OP_BYTE, 8'hFF}, {OP_BYTE, 8'h80},
         {OP_BYTE, 8'hF8}, {OP_BYTE, 8'hC3}, {OP_BYTE, 8'hA9}, {OP_BYTE, 8'hE2},
         {OP_BYTE, 8'h82}, {OP_BYTE, 8'hAC}, {OP_BYTE, 8'hF0}, {OP_BYTE, 8'h9F},
         {OP_BYTE, 8'h98}, {OP_BYTE, 8'h80}, {OP_BYTE, NL_BYTE},
         {OP_BYTE, 8'hE2}, {OP_BYTE, NL_BYTE}, {OP_BYTE, NL_BYTE}, {OP_BYTE, NL_BYTE},
         {OP_BYTE, 8'hF0}, {OP_BYTE, 8'h9F}, {OP_END, 8'h00}
      };
      int unsigned target;

      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_BYTE;
      req_text_byte = 8'h00;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (opening[i]) send_beat(opening[i][8], opening[i][7:0]);
      pause_until_drained();

      // receiver holds off while line ends stream in back to back
      long_hold = 1'b1;
      req_steady = 1'b1;
      repeat (16) send_beat(OP_BYTE, NL_BYTE);
      send_beat(OP_END, 8'h00);
      req_steady = 1'b0;
      pause_until_drained();

      for (int phase = 0; phase < 4; phase++) begin
         req_steady = (phase == 1);
         rsp_steady = (phase == 1);
         target = board.n_beats + RANDOM_BEATS / 4;
         while (board.n_beats < target) send_char();
         pause_until_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d request beats over %0d texts, %0d line records checked,",
               board.n_beats, board.n_texts, board.n_lines);
      $display("with random gaps on both sides and %0d long receiver hold-off.",
               long_holds);
      if (board.n_errors == 0 && board.pending_lines.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
